### rtl/core/gbfp_pkg.sv
// Package with the phase codes, constants and result type of the frame parser.
`default_nettype none
package gbfp_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hBA;
  localparam logic [7:0] SYNC_SECOND = 8'hCE;
  localparam logic [15:0] MAX_LEN_RESET = 16'd1024;

  typedef enum logic [3:0] {
    PH_SYNC1   = 4'd0,
    PH_SYNC2   = 4'd1,
    PH_LEN_LO  = 4'd2,
    PH_LEN_HI  = 4'd3,
    PH_CLASS   = 4'd4,
    PH_ID      = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CK0     = 4'd7,
    PH_CK1     = 4'd8,
    PH_CK2     = 4'd9,
    PH_CK3     = 4'd10
  } phase_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic        frame_end;
    logic        checksum_ok;
    logic        length_error;
    logic [7:0]  frame_class;
    logic [7:0]  frame_id;
    logic [15:0] frame_length;
  } result_t;

endpackage
`default_nettype wire

### rtl/core/gbfp_if.sv
// Valid/ready channel interfaces for received bytes and parser results.
`default_nettype none
interface gbfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface gbfp_result_if;
  logic        valid;
  logic        ready;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic [15:0] payload_index;
  logic        frame_end;
  logic        checksum_ok;
  logic        length_error;
  logic [7:0]  frame_class;
  logic [7:0]  frame_id;
  logic [15:0] frame_length;
  modport source (output valid, output payload_valid, output payload_byte,
                  output payload_index, output frame_end, output checksum_ok,
                  output length_error, output frame_class, output frame_id,
                  output frame_length, input ready);
  modport sink   (input valid, input payload_valid, input payload_byte,
                  input payload_index, input frame_end, input checksum_ok,
                  input length_error, input frame_class, input frame_id,
                  input frame_length, output ready);
endinterface
`default_nettype wire

### rtl/core/gbfp_frame_fsm.sv
// Frame state machine: parse state, checksum accumulation and per-byte result.
`default_nettype none
module gbfp_frame_fsm
  import gbfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step_en,
  input  wire logic [7:0]  rx_byte,
  input  wire logic [15:0] max_len,
  output result_t          res
);

  phase_t      phase, phase_next;
  logic [15:0] length_reg, length_reg_next;
  logic [7:0]  class_reg, class_reg_next;
  logic [7:0]  ident_reg, ident_reg_next;
  logic [15:0] byte_count, byte_count_next;
  logic [31:0] sum_accum, sum_accum_next;
  logic [23:0] word_bytes, word_bytes_next;
  logic [23:0] rx_sum_bytes, rx_sum_bytes_next;

  logic [15:0] len_full;
  logic [15:0] count_inc;

  assign len_full  = {rx_byte, length_reg[7:0]};
  assign count_inc = byte_count + 16'd1;

  // Next phase.
  always_comb begin
    case (phase)
      PH_SYNC2: begin
        if (rx_byte == SYNC_SECOND) phase_next = PH_LEN_LO;
        else if (rx_byte == SYNC_FIRST) phase_next = PH_SYNC2;
        else phase_next = PH_SYNC1;
      end
      PH_LEN_LO: phase_next = PH_LEN_HI;
      PH_LEN_HI: phase_next = (len_full > max_len) ? PH_SYNC1 : PH_CLASS;
      PH_CLASS:  phase_next = PH_ID;
      PH_ID:     phase_next = (length_reg == 16'd0) ? PH_CK0 : PH_PAYLOAD;
      PH_PAYLOAD: phase_next = (count_inc == length_reg) ? PH_CK0 : PH_PAYLOAD;
      PH_CK0:    phase_next = PH_CK1;
      PH_CK1:    phase_next = PH_CK2;
      PH_CK2:    phase_next = PH_CK3;
      PH_CK3:    phase_next = PH_SYNC1;
      default:   phase_next = (rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
    endcase
  end

  // Data registers and result fields.
  always_comb begin
    length_reg_next   = length_reg;
    class_reg_next    = class_reg;
    ident_reg_next    = ident_reg;
    byte_count_next   = byte_count;
    sum_accum_next    = sum_accum;
    word_bytes_next   = word_bytes;
    rx_sum_bytes_next = rx_sum_bytes;
    res               = '0;
    case (phase)
      PH_LEN_LO: length_reg_next = {8'd0, rx_byte};
      PH_LEN_HI: begin
        length_reg_next  = len_full;
        res.length_error = (len_full > max_len);
      end
      PH_CLASS: class_reg_next = rx_byte;
      PH_ID: begin
        ident_reg_next  = rx_byte;
        sum_accum_next  = {rx_byte, class_reg, length_reg};
        byte_count_next = 16'd0;
        word_bytes_next = 24'd0;
      end
      PH_PAYLOAD: begin
        res.payload_valid = 1'b1;
        res.payload_byte  = rx_byte;
        res.payload_index = byte_count;
        byte_count_next   = count_inc;
        case (byte_count[1:0])
          2'd0: word_bytes_next = {16'd0, rx_byte};
          2'd1: word_bytes_next = {word_bytes[23:16], rx_byte, word_bytes[7:0]};
          2'd2: word_bytes_next = {rx_byte, word_bytes[15:0]};
          default: begin
            sum_accum_next  = sum_accum + {rx_byte, word_bytes};
            word_bytes_next = 24'd0;
          end
        endcase
      end
      PH_CK0: rx_sum_bytes_next = {16'd0, rx_byte};
      PH_CK1: rx_sum_bytes_next = {8'd0, rx_byte, rx_sum_bytes[7:0]};
      PH_CK2: rx_sum_bytes_next = {rx_byte, rx_sum_bytes[15:0]};
      PH_CK3: begin
        res.frame_end   = 1'b1;
        res.checksum_ok = ({rx_byte, rx_sum_bytes} == sum_accum);
      end
      default: ;
    endcase
    res.frame_class  = class_reg_next;
    res.frame_id     = ident_reg_next;
    res.frame_length = length_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SYNC1;
      length_reg   <= '0;
      class_reg    <= '0;
      ident_reg    <= '0;
      byte_count   <= '0;
      sum_accum    <= '0;
      word_bytes   <= '0;
      rx_sum_bytes <= '0;
    end else if (step_en) begin
      phase        <= phase_next;
      length_reg   <= length_reg_next;
      class_reg    <= class_reg_next;
      ident_reg    <= ident_reg_next;
      byte_count   <= byte_count_next;
      sum_accum    <= sum_accum_next;
      word_bytes   <= word_bytes_next;
      rx_sum_bytes <= rx_sum_bytes_next;
    end
  end

endmodule
`default_nettype wire

### rtl/core/gnss_binary_frame_parser_core.sv
// Top level of the binary GNSS frame parser: input stage, parser and result register.
//
// Usage: received bytes enter on the rx channel, one byte per beat. Every
// byte produces exactly one result beat on the result channel, in order.
// A result carries the payload byte and its index when the byte was
// payload, frame_end and checksum_ok on the last checksum byte,
// length_error when a declared length exceeds max_payload_len, and the
// class, id and length of the current frame.
// An accepted byte waits in the input register, then the parser updates
// its state and writes the result register. Throughput is one byte per
// cycle while the receiver is not stalled, set by the state update and
// 32-bit checksum add in the parser. The input register lets one more
// byte be taken while a result waits for a stalled receiver; after that
// rx.ready drops until the result beat is taken. Synchronous reset
// empties both stages, returns the parser to hunting for the first sync
// byte, clears its registers and sets max_payload_len to 1024. Write
// cfg_wr_en/cfg_wr_data only while the block is idle.
`default_nettype none
module gnss_binary_frame_parser_core
  import gbfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  gbfp_byte_if.sink        rx,
  gbfp_result_if.source    result
);

  // Configuration register for the largest accepted payload length.
  logic [15:0] max_payload_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload_len <= MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_payload_len <= cfg_wr_data;
    end
  end

  // Input stage holds one byte; it moves on when the result register is
  // free or being emptied in this cycle.
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       out_valid;
  result_t    out_res;
  result_t    step_res;
  logic       advance;

  assign advance  = s1_valid && (!out_valid || result.ready);
  assign rx.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      s1_byte <= rx.rx_byte;
    end
  end

  // The parser commits its state exactly when its result is registered.
  gbfp_frame_fsm u_fsm (
    .clk     (clk),
    .rst     (rst),
    .step_en (advance),
    .rx_byte (s1_byte),
    .max_len (max_payload_len),
    .res     (step_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign result.valid         = out_valid;
  assign result.payload_valid = out_res.payload_valid;
  assign result.payload_byte  = out_res.payload_byte;
  assign result.payload_index = out_res.payload_index;
  assign result.frame_end     = out_res.frame_end;
  assign result.checksum_ok   = out_res.checksum_ok;
  assign result.length_error  = out_res.length_error;
  assign result.frame_class   = out_res.frame_class;
  assign result.frame_id      = out_res.frame_id;
  assign result.frame_length  = out_res.frame_length;

  // A byte is never taken into a full input stage that is not moving on.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (rx.valid && rx.ready) |-> (!s1_valid || advance))
    else $error("input stage overrun");

  // Every parser step shows up as a result beat in the next cycle.
  a_step_to_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> result.valid)
    else $error("parser step lost");

  // A payload beat always lies inside the declared length.
  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.payload_valid) |->
      (result.payload_index < result.frame_length))
    else $error("payload index beyond frame length");

endmodule
`default_nettype wire
